@@ rtl/core/psc_pkg.sv @@
// Shared types, constants and the microcode program of the prime sieve counter.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package psc_pkg;

	localparam int LIMIT_W       = 17;
	localparam int COUNT_W       = 13;
	localparam int DEF_MAX_LIMIT = 65536;
	localparam int FIRST_PRIME   = 2;
	localparam int STEP_W        = 4;

	typedef logic [STEP_W-1:0] step_t;

	// Datapath operation selected by the current microinstruction.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_INIT_P,
		OP_SQUARE,
		OP_START_MARK,
		OP_MARK,
		OP_INC_P,
		OP_READ_P,
		OP_CNT_START,
		OP_COUNT,
		OP_EMIT
	} op_t;

	// Jump condition: when true the sequencer goes to the target, else to the next step.
	typedef enum logic [3:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_NO_INPUT,
		CND_NOT_LAST,
		CND_LIM_SMALL,
		CND_SQ_GT,
		CND_MARK_MORE,
		CND_P_GT,
		CND_COMPOSITE,
		CND_M_LE,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic not_last;
		logic lim_small;
		logic sq_gt;
		logic mark_more;
		logic p_gt;
		logic composite;
		logic m_le;
		logic out_busy;
	} flags_t;

	localparam step_t ST_IDLE = 4'd0;
	localparam step_t ST_CLR  = 4'd1;
	localparam step_t ST_INIT = 4'd2;
	localparam step_t ST_SQ   = 4'd3;
	localparam step_t ST_TSQ  = 4'd4;
	localparam step_t ST_MARK = 4'd5;
	localparam step_t ST_INC  = 4'd6;
	localparam step_t ST_RDP  = 4'd7;
	localparam step_t ST_TST  = 4'd8;
	localparam step_t ST_GO   = 4'd9;
	localparam step_t ST_CNT0 = 4'd10;
	localparam step_t ST_CNT  = 4'd11;
	localparam step_t ST_EMIT = 4'd12;
	localparam step_t ST_WRAP = 4'd13;

	// The sieve program.
	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		unique case (s)
			ST_IDLE: w = '{op: OP_LOAD,       cond: CND_NO_INPUT,  target: ST_IDLE};
			ST_CLR:  w = '{op: OP_CLEAR,      cond: CND_NOT_LAST,  target: ST_CLR};
			ST_INIT: w = '{op: OP_INIT_P,     cond: CND_LIM_SMALL, target: ST_EMIT};
			ST_SQ:   w = '{op: OP_SQUARE,     cond: CND_NEXT,      target: ST_IDLE};
			ST_TSQ:  w = '{op: OP_START_MARK, cond: CND_SQ_GT,     target: ST_CNT0};
			ST_MARK: w = '{op: OP_MARK,       cond: CND_MARK_MORE, target: ST_MARK};
			ST_INC:  w = '{op: OP_INC_P,      cond: CND_NEXT,      target: ST_IDLE};
			ST_RDP:  w = '{op: OP_READ_P,     cond: CND_P_GT,      target: ST_SQ};
			ST_TST:  w = '{op: OP_NONE,       cond: CND_COMPOSITE, target: ST_INC};
			ST_GO:   w = '{op: OP_NONE,       cond: CND_ALWAYS,    target: ST_SQ};
			ST_CNT0: w = '{op: OP_CNT_START,  cond: CND_NEXT,      target: ST_IDLE};
			ST_CNT:  w = '{op: OP_COUNT,      cond: CND_M_LE,      target: ST_CNT};
			ST_EMIT: w = '{op: OP_EMIT,       cond: CND_OUT_BUSY,  target: ST_EMIT};
			ST_WRAP: w = '{op: OP_NONE,       cond: CND_ALWAYS,    target: ST_IDLE};
			default: w = '{op: OP_NONE,       cond: CND_ALWAYS,    target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/prime_sieve_counter_top.sv @@
// Top level of the prime sieve counter: microcode sequencer plus sieve datapath.
// Depends on psc_pkg, psc_sequencer and psc_datapath.
//
// Usage: one transaction on the input channel (in_valid/in_ready, limit) asks
// for the number of primes <= limit; exactly one transaction on the output
// channel (out_valid/out_ready, prime_count) answers it, in request order.
// Limits above MAX_LIMIT are saturated to MAX_LIMIT; a limit below 2 gives 0.
// Work is done one request at a time over a single-bit memory with one write
// and one read port. For a limit n the sequencer clears bits 0 to n, marks the
// multiples of each prime p with p*p <= n from p*p up to n, and then counts the
// unmarked bits from 2 to n.
// in_ready is high only while the sequencer waits for a request;
// the next request may be accepted while the previous result still waits in
// the output register. If the receiver stalls, the result is held and the
// sequencer waits before loading a following one. Reset (arst_n low) returns
// the sequencer to its wait step and drops out_valid; no memory sweep follows,
// since every request clears the bitmap up to its own limit.
`timescale 1ns / 1ps

module prime_sieve_counter_top
	import psc_pkg::*;
#(
	parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LIMIT_W-1:0] limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] prime_count
);

	ctrl_t  ctrl;
	flags_t flags;

	psc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	psc_datapath #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.flags       (flags),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.limit       (limit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime_count (prime_count)
	);

endmodule

@@ rtl/core/psc_sequencer.sv @@
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on psc_pkg for the program, the control word and the flag struct.
`timescale 1ns / 1ps

module psc_sequencer
	import psc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	step_t  upc_q;
	step_t  upc_next;
	uword_t uword;
	logic   take;

	assign uword   = ucode_rom(upc_q);
	assign ctrl.op = uword.op;

	always_comb begin
		unique case (uword.cond)
			CND_NEXT:      take = 1'b0;
			CND_ALWAYS:    take = 1'b1;
			CND_NO_INPUT:  take = !flags.in_fire;
			CND_NOT_LAST:  take = flags.not_last;
			CND_LIM_SMALL: take = flags.lim_small;
			CND_SQ_GT:     take = flags.sq_gt;
			CND_MARK_MORE: take = flags.mark_more;
			CND_P_GT:      take = flags.p_gt;
			CND_COMPOSITE: take = flags.composite;
			CND_M_LE:      take = flags.m_le;
			CND_OUT_BUSY:  take = flags.out_busy;
			default:       take = 1'b1;
		endcase
	end

	assign upc_next = take ? uword.target : upc_q + step_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

@@ rtl/core/psc_datapath.sv @@
// Sieve datapath: limit, prime, address and count registers, the squarer,
// the composite bitmap memory and the output register. Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_datapath
	import psc_pkg::*;
#(
	parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	output flags_t             flags,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LIMIT_W-1:0] limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] prime_count
);

	localparam int DEPTH = MAX_LIMIT + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = AW + 1;
	localparam int SW    = 2 * NW;
	localparam int CW    = (NW > LIMIT_W) ? NW : LIMIT_W;

	logic               mem [DEPTH];
	logic               rdata_q;

	logic [AW-1:0]      n_q;
	logic [NW-1:0]      p_q;
	logic [NW-1:0]      m_q;
	logic [SW-1:0]      sq_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_valid_q;
	logic               cnt_pend_q;

	logic [NW-1:0]      n_ext;
	logic [NW-1:0]      m_next;
	logic [CW-1:0]      lim_ext;
	logic [AW-1:0]      n_sat;
	logic               in_fire;
	logic               wr_en;
	logic               wr_bit;
	logic               rd_en;
	logic [AW-1:0]      raddr;
	logic               emit;

	assign n_ext   = NW'(n_q);
	assign m_next  = m_q + p_q;
	assign lim_ext = CW'(limit);
	assign n_sat   = (lim_ext > CW'(MAX_LIMIT)) ? AW'(MAX_LIMIT) : AW'(limit);

	assign in_ready = (ctrl.op == OP_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign emit     = (ctrl.op == OP_EMIT) && !flags.out_busy;

	assign flags.in_fire   = in_fire;
	assign flags.not_last  = (m_q != n_ext);
	assign flags.lim_small = (n_q < AW'(FIRST_PRIME));
	assign flags.sq_gt     = (sq_q > SW'(n_q));
	assign flags.mark_more = (m_next <= n_ext);
	assign flags.p_gt      = (p_q > n_ext);
	assign flags.composite = rdata_q;
	assign flags.m_le      = (m_q <= n_ext);
	assign flags.out_busy  = out_valid_q && !out_ready;

	// Clearing and marking share the single write port; both address through m_q.
	assign wr_en  = (ctrl.op == OP_CLEAR) || (ctrl.op == OP_MARK);
	assign wr_bit = (ctrl.op == OP_MARK);
	assign rd_en  = ((ctrl.op == OP_READ_P) && !flags.p_gt) ||
	                ((ctrl.op == OP_COUNT) && flags.m_le);
	assign raddr  = (ctrl.op == OP_READ_P) ? p_q[AW-1:0] : m_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[m_q[AW-1:0]] <= wr_bit;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_fire) begin
					n_q   <= n_sat;
					m_q   <= '0;
					cnt_q <= '0;
				end
			end
			OP_CLEAR:      m_q <= m_q + NW'(1);
			OP_INIT_P:     p_q <= NW'(FIRST_PRIME);
			OP_SQUARE:     sq_q <= SW'(p_q) * SW'(p_q);
			OP_START_MARK: m_q <= sq_q[NW-1:0];
			OP_MARK:       m_q <= m_next;
			OP_INC_P:      p_q <= p_q + NW'(1);
			OP_CNT_START:  m_q <= NW'(FIRST_PRIME);
			OP_COUNT: begin
				if (flags.m_le) begin
					m_q <= m_q + NW'(1);
				end
			end
			OP_NONE, OP_READ_P, OP_EMIT: begin
			end
			default: begin
			end
		endcase
		// Counting runs in the cycle after its bitmap read.
		if (cnt_pend_q && !rdata_q) begin
			cnt_q <= cnt_q + COUNT_W'(1);
		end
		if (emit) begin
			out_count_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_pend_q <= (ctrl.op == OP_COUNT) && flags.m_le;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_count = out_count_q;

endmodule

@@ rtl/core/psc_checker.sv @@
// Port-level checker for the prime sieve counter, bound to the top level.
// Depends on psc_pkg for field widths.
`timescale 1ns / 1ps

module psc_checker
	import psc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [LIMIT_W-1:0] limit,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COUNT_W-1:0] prime_count
);

	// A result that is not taken stays offered with the same count.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_count))
		else $error("result dropped or changed while stalled");

	// A waiting request keeps its limit until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(limit))
		else $error("request dropped or changed while waiting");

	// The sieve work comes first, so a result never appears right after a request.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared in the cycle after a request");

	// The block keeps waiting for a request until one is taken.
	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input ready dropped without a transaction");

	// Two requests are never taken back to back; each one clears the bitmap first.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while sieve busy");

endmodule

bind prime_sieve_counter_top psc_checker u_psc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.limit       (limit),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.prime_count (prime_count)
);

@@ tb/tb.sv @@
// Self-checking testbench for prime_sieve_counter_top: directed limits from a table,
// then random limits, each count checked against a typed count or an in-bench sieve.
// Depends on psc_pkg and the prime sieve counter RTL.
`timescale 1ns / 1ps

module tb
	import psc_pkg::*;
;

	localparam int SIEVE_MAX      = DEF_MAX_LIMIT;
	localparam int DIR_N          = 22;
	localparam int RANDOM_ITEMS   = 78;
	localparam int HOLD_AFTER     = DIR_N + 10;
	localparam int LONG_HOLD      = 5000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 1500000;
	localparam logic GIVEN        = 1'b1;
	localparam logic PREDICT      = 1'b0;

	typedef enum logic [1:0] {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] lim;
		logic               known;
		logic [COUNT_W-1:0] count;
	} limit_row_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] lim;
		logic [COUNT_W-1:0] count;
	} count_expect_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [LIMIT_W-1:0] limit     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] prime_count;

	count_expect_t pending_counts[$];
	bit            crossed_out [0:SIEVE_MAX];
	int            mismatches    = 0;
	int            results_seen  = 0;
	int            directed_sent = 0;
	int            random_sent   = 0;
	int            burst_left    = 0;
	int            idle_cycles   = 0;
	logic [LIMIT_W-1:0] largest_limit = '0;

	// Typed counts are the obvious ones; the rest come from the sieve below.
	limit_row_t directed_rows [DIR_N] = '{
		'{17'd0,      GIVEN,   13'd0},
		'{17'd1,      GIVEN,   13'd0},
		'{17'd2,      GIVEN,   13'd1},
		'{17'd3,      GIVEN,   13'd2},
		'{17'd4,      GIVEN,   13'd2},
		'{17'd5,      PREDICT, 13'd0},
		'{17'd8,      PREDICT, 13'd0},
		'{17'd9,      PREDICT, 13'd0},
		'{17'd10,     PREDICT, 13'd0},
		'{17'd24,     PREDICT, 13'd0},
		'{17'd25,     PREDICT, 13'd0},
		'{17'd48,     PREDICT, 13'd0},
		'{17'd49,     PREDICT, 13'd0},
		'{17'd97,     PREDICT, 13'd0},
		'{17'd120,    PREDICT, 13'd0},
		'{17'd121,    PREDICT, 13'd0},
		'{17'd168,    PREDICT, 13'd0},
		'{17'd169,    PREDICT, 13'd0},
		'{17'd1000,   PREDICT, 13'd0},
		'{17'd131071, GIVEN,   13'd6542},
		'{17'd65536,  GIVEN,   13'd6542},
		'{17'd11,     PREDICT, 13'd0}
	};

	prime_sieve_counter_top #(
		.MAX_LIMIT(SIEVE_MAX)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.limit      (limit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_count(prime_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [COUNT_W-1:0] primes_upto(input logic [LIMIT_W-1:0] lim);
		int unsigned n;
		int unsigned p;
		int unsigned m;
		int unsigned total;
		n = (lim > SIEVE_MAX) ? SIEVE_MAX : lim;
		if (n < FIRST_PRIME)
			return '0;
		for (m = 0; m <= n; m++)
			crossed_out[m] = 1'b0;
		for (p = FIRST_PRIME; p * p <= n; p++) begin
			if (!crossed_out[p]) begin
				for (m = p * p; m <= n; m += p)
					crossed_out[m] = 1'b1;
			end
		end
		total = 0;
		for (m = FIRST_PRIME; m <= n; m++) begin
			if (!crossed_out[m])
				total++;
		end
		return total[COUNT_W-1:0];
	endfunction

	// Mostly small limits keep the run short; a few reach into the thousands.
	function automatic logic [LIMIT_W-1:0] random_limit();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return LIMIT_W'($urandom_range(0, 16));
		else if (pick < 90)
			return LIMIT_W'($urandom_range(17, 400));
		else
			return LIMIT_W'($urandom_range(401, 4095));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Bursts of back-to-back requests separated by random gaps.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Valid stays high after the transaction; the caller lowers it if a gap follows.
	task automatic send_limit(input logic [LIMIT_W-1:0] lim, input logic known,
			input logic [COUNT_W-1:0] count);
		count_expect_t exp_item;
		in_valid <= 1'b1;
		limit    <= lim;
		do
			@(posedge clk);
		while (!in_ready);
		exp_item.lim   = lim;
		exp_item.count = known ? count : primes_upto(lim);
		pending_counts.push_back(exp_item);
		if (lim > largest_limit)
			largest_limit = lim;
	endtask

	initial begin : stimulus
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < DIR_N; i++) begin
			pace_sender();
			send_limit(directed_rows[i].lim, directed_rows[i].known, directed_rows[i].count);
			directed_sent++;
		end
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pace_sender();
			send_limit(random_limit(), PREDICT, '0);
			random_sent++;
		end
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d directed and %0d random limits (largest %0d), %0d counts received.",
			directed_sent, random_sent, largest_limit, results_seen);
		$display("The receiver held off for %0d cycles once so that the input stalled.",
			LONG_HOLD);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		bit       held_off;
		mode      = RX_STREAM;
		mode_left = 0;
		held_off  = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= HOLD_AFTER) begin
				// Long stall: the block keeps one result and one request, then blocks input.
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				case (mode)
					RX_STREAM: out_ready <= 1'b1;
					RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_counts
		count_expect_t head;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_counts.size() == 0) begin
				report_mismatch($sformatf("prime_count %0d with no request outstanding",
					prime_count));
			end else begin
				head = pending_counts.pop_front();
				if (prime_count !== head.count)
					report_mismatch($sformatf("limit %0d: prime_count %0d, expected %0d",
						head.lim, prime_count, head.count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d counts outstanding",
				idle_cycles, pending_counts.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

@@ sim.f @@
rtl/core/psc_pkg.sv
rtl/core/psc_sequencer.sv
rtl/core/psc_datapath.sv
rtl/core/prime_sieve_counter_top.sv
rtl/core/psc_checker.sv
tb/tb.sv
